// File: rtl/hack_cpu_core_extended_alu_unit_macros.svh
// Assertion macros for the extended ALU CPU core.
`ifndef HACK_CPU_CORE_EXTENDED_ALU_UNIT_MACROS_SVH
`define HACK_CPU_CORE_EXTENDED_ALU_UNIT_MACROS_SVH
`define HCA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/hca_pkg.sv
// Package with types, codes and helpers of the extended ALU CPU core.
package hca_pkg;
    localparam int unsigned InstrDepthDefault = 32768;
    localparam int unsigned DataW = 16;
    localparam int unsigned PcW = 15;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_HALT = 3'd1, ST_SERVICE = 3'd2, ST_CALLRET = 3'd3,
        ST_IO = 3'd4, ST_ILLEGAL = 3'd5, ST_DIVZERO = 3'd6
    } t_status;

    localparam logic [5:0] C_DIV = 6'h23;
    localparam logic [5:0] C_MOD = 6'h24;

    typedef struct packed {
        logic [15:0] instruction;
        logic signed [15:0] mem_read_data;
    } t_in_word;

    typedef struct packed {
        logic [2:0] status;
        logic [14:0] next_pc;
        logic signed [15:0] a_value;
        logic signed [15:0] d_value;
        logic mem_write;
        logic signed [15:0] mem_write_data;
        logic signed [15:0] service_a;
        logic signed [15:0] service_d;
    } t_out_word;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_FINISH, S_OUT} t_state;

    typedef struct packed {
        logic start;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic needs_div;
        logic div_done;
    } t_stat;
endpackage

// File: rtl/hack_cpu_core_extended_alu_unit.sv
// Top level of the extended ALU CPU core.
//   channel | direction | handshake
//   in      | input     | i_in_valid / o_in_ready, word i_in
//   out     | output    | o_out_valid / i_out_ready, word o_out
//   cfg     | input     | i_cfg_valid / o_cfg_ready, i_cfg_data
// A word passes through S_DIV and S_FINISH, then waits in S_OUT for the output handshake.
// Divide and modulo with a nonzero divisor run the serial divider while in S_DIV.
// Reset clears A, D, PC and the program length.
// A stalled output holds the core; no new word is taken until it leaves.
`include "hack_cpu_core_extended_alu_unit_macros.svh"
module hack_cpu_core_extended_alu_unit import hca_pkg::*; #(
    parameter int unsigned INSTR_DEPTH = InstrDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    t_cmd cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    hca_control u_ctl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_stat(stat), .o_cmd(cmd)
    );

    hca_datapath #(.INSTR_DEPTH(INSTR_DEPTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat), .i_in,
        .i_cfg_valid, .i_cfg_data, .o_out
    );

    `HCA_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `HCA_ASSERT_IMPL(a_one_cmd, i_clk, i_rst_n, 1'b1,
        $countones({cmd.start, cmd.div_step, cmd.finish}) <= 1)
    `HCA_ASSERT_NEXT(a_finish_out, i_clk, i_rst_n, cmd.finish, o_out_valid)
endmodule

// File: rtl/hca_datapath.sv
// Datapath of the extended ALU CPU core: registers, ALU and serial divider.
module hca_datapath import hca_pkg::*; #(
    parameter int unsigned INSTR_DEPTH = InstrDepthDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    input  t_in_word  i_in,
    input  logic      i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    output t_out_word o_out
);
    localparam logic [16:0] Lim = 17'(INSTR_DEPTH);

    logic [15:0] r_a, r_d, r_len;
    logic [14:0] r_pc;
    logic [15:0] r_ins, r_m;
    logic [15:0] r_rem, r_quo, r_dvs;
    logic [4:0] r_cnt;
    logic r_nneg, r_qneg;
    t_out_word r_out;

    logic [5:0] comp;
    logic [15:0] amv, d_mag, m_mag;
    logic [16:0] limit, diff;
    logic [15:0] rem_sh;

    assign comp = r_ins[11:6];
    assign amv = r_ins[12] ? r_m : r_a;
    assign limit = ({1'b0, r_len} > Lim) ? Lim : {1'b0, r_len};
    assign d_mag = r_d[15] ? 16'(-r_d) : r_d;
    assign m_mag = amv[15] ? 16'(-amv) : amv;
    assign rem_sh = {r_rem[14:0], r_quo[15]};
    assign diff = {1'b0, rem_sh} - {1'b0, r_dvs};

    assign o_stat.needs_div = (r_ins[15:13] == 3'b111) && ({1'b0, r_pc} < limit)
        && (comp == C_DIV || comp == C_MOD) && (amv != 16'd0);
    assign o_stat.div_done = (r_cnt == 5'd17);
    assign o_out = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cfg_valid) begin
            r_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ins <= i_in.instruction;
            r_m <= i_in.mem_read_data;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            if (r_cnt == 5'd0 && !o_stat.div_done) begin
                r_rem <= '0;
                r_quo <= d_mag;
                r_dvs <= m_mag;
                r_nneg <= r_d[15];
                r_qneg <= r_d[15] ^ amv[15];
                r_cnt <= 5'd1;
            end else begin
                if (!diff[16]) begin
                    r_rem <= diff[15:0];
                    r_quo <= {r_quo[14:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[14:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    logic [15:0] res, n_a, n_d;
    logic [14:0] n_pc, pc_inc;
    t_status st;
    logic take, wr;
    logic [31:0] prod;
    always_comb begin
        res = '0;
        st = ST_OK;
        prod = r_d * amv;
        case (comp)
            6'h00: res = r_d & amv;
            6'h02: res = r_d + amv;
            6'h07: res = amv - r_d;
            6'h0C: res = r_d;
            6'h0D: res = ~r_d;
            6'h0E: res = r_d - 16'd1;
            6'h0F: res = 16'd0 - r_d;
            6'h13: res = r_d - amv;
            6'h15: res = r_d | amv;
            6'h1F: res = r_d + 16'd1;
            6'h30: res = amv;
            6'h31: res = ~amv;
            6'h32: res = amv - 16'd1;
            6'h33: res = 16'd0 - amv;
            6'h37: res = amv + 16'd1;
            6'h3A: res = 16'hFFFF;
            6'h3F: res = 16'd1;
            6'h20: res = (amv >= 16'd16) ? 16'd0 : (r_d << amv[3:0]);
            6'h21: res = (amv >= 16'd16) ? {16{r_d[15]}}
                       : 16'($signed(r_d) >>> amv[3:0]);
            6'h22: res = prod[15:0];
            C_DIV: begin
                if (amv == 16'd0) st = ST_DIVZERO;
                else res = r_qneg ? 16'(-r_quo) : r_quo;
            end
            C_MOD: begin
                if (amv == 16'd0) st = ST_DIVZERO;
                else res = r_nneg ? 16'(-r_rem) : r_rem;
            end
            6'h25: res = {15'd0, $signed(r_d) < $signed(amv)};
            6'h26: res = {15'd0, $signed(r_d) <= $signed(amv)};
            6'h27: res = {15'd0, $signed(r_d) > $signed(amv)};
            6'h28: res = {15'd0, $signed(r_d) >= $signed(amv)};
            6'h29: res = {15'd0, r_d == amv};
            6'h2B: res = {15'd0, r_d != amv};
            6'h2C: res = r_d ^ amv;
            6'h2D, 6'h2E: st = ST_CALLRET;
            6'h2F: st = ST_SERVICE;
            default: res = '0;
        endcase
        pc_inc = r_pc + 15'd1;
        n_a = r_a;
        n_d = r_d;
        n_pc = r_pc;
        wr = 1'b0;
        take = 1'b0;
        if ({1'b0, r_pc} >= limit) begin
            st = ST_HALT;
        end else if (!r_ins[15]) begin
            st = ST_OK;
            n_a = r_ins;
            n_pc = pc_inc;
        end else if (!r_ins[14]) begin
            st = ST_IO;
        end else if (!r_ins[13]) begin
            st = ST_ILLEGAL;
        end else if (st == ST_OK || st == ST_SERVICE) begin
            if (r_ins[5]) n_a = res;
            if (r_ins[4]) n_d = res;
            wr = r_ins[3];
            case (r_ins[2:0])
                3'd1: take = !res[15] && res != 16'd0;
                3'd2: take = res == 16'd0;
                3'd3: take = !res[15];
                3'd4: take = res[15];
                3'd5: take = res != 16'd0;
                3'd6: take = res[15] || res == 16'd0;
                3'd7: take = 1'b1;
                default: take = 1'b0;
            endcase
            n_pc = take ? n_a[14:0] : pc_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_d <= '0;
            r_pc <= '0;
        end else if (i_cmd.finish) begin
            r_a <= n_a;
            r_d <= n_d;
            r_pc <= n_pc;
            r_out.status <= st;
            r_out.next_pc <= n_pc;
            r_out.a_value <= n_a;
            r_out.d_value <= n_d;
            r_out.mem_write <= wr;
            r_out.mem_write_data <= wr ? res : 16'd0;
            r_out.service_a <= r_a;
            r_out.service_d <= r_d;
        end
    end
endmodule

// File: rtl/hca_control.sv
// Controller state machine of the extended ALU CPU core.
module hca_control import hca_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_DIV;
            S_DIV: if (!i_stat.needs_div || i_stat.div_done) n_state = S_FINISH;
            S_FINISH: n_state = S_OUT;
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT);
        o_cmd.start = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_step = (r_state == S_DIV) && i_stat.needs_div && !i_stat.div_done;
        o_cmd.finish = (r_state == S_FINISH);
    end
endmodule

// File: verif/hack_cpu_core_extended_alu_unit_test.sv
// Self-checking testbench for the extended ALU CPU core: directed table, then random programs.
`timescale 1ns / 1ps
module hack_cpu_core_extended_alu_unit_test;
    import hca_pkg::*;

    localparam logic [5:0] OP_AND = 6'h00, OP_ADD = 6'h02, OP_AMD = 6'h07, OP_D = 6'h0C;
    localparam logic [5:0] OP_NOTD = 6'h0D, OP_DM1 = 6'h0E, OP_NEGD = 6'h0F, OP_DMA = 6'h13;
    localparam logic [5:0] OP_OR = 6'h15, OP_DP1 = 6'h1F, OP_A = 6'h30, OP_NOTA = 6'h31;
    localparam logic [5:0] OP_AM1 = 6'h32, OP_NEGA = 6'h33, OP_AP1 = 6'h37, OP_NEG1 = 6'h3A;
    localparam logic [5:0] OP_ONE = 6'h3F, OP_SHL = 6'h20, OP_SHR = 6'h21, OP_MUL = 6'h22;
    localparam logic [5:0] OP_LT = 6'h25, OP_LE = 6'h26, OP_GT = 6'h27, OP_GE = 6'h28;
    localparam logic [5:0] OP_EQ = 6'h29, OP_ZERO = 6'h2A, OP_NE = 6'h2B, OP_XOR = 6'h2C;
    localparam logic [5:0] OP_CALL = 6'h2D, OP_RET = 6'h2E, OP_SVC = 6'h2F, OP_UNUSED = 6'h01;
    localparam logic [2:0] DST_NONE = 3'b000, DST_M = 3'b001, DST_D = 3'b010, DST_A = 3'b100;
    localparam logic [2:0] J_NONE = 3'd0, J_GT = 3'd1, J_EQ = 3'd2, J_GE = 3'd3;
    localparam logic [2:0] J_LT = 3'd4, J_NE = 3'd5, J_LE = 3'd6, J_ALWAYS = 3'd7;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 40;

    typedef struct {
        t_in_word w;
        bit known;
        t_out_word exp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_word i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_word o_out;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    logic [15:0] cpu_a = '0, cpu_d = '0;
    logic [14:0] cpu_pc = '0;
    logic [15:0] prog_len = '0;
    t_out_word pending_results[$];
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    bit out_throttle = 1'b0;
    bit in_throttle = 1'b0;
    int unsigned out_hold = 0;
    t_row steps[$];

    hack_cpu_core_extended_alu_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [15:0] cinstr(logic abit, logic [5:0] comp, logic [2:0] dst,
                                           logic [2:0] jmp);
        return {3'b111, abit, comp, dst, jmp};
    endfunction

    function automatic t_out_word execute_instr(t_in_word w);
        t_out_word o;
        logic [15:0] ins, mv, r;
        logic [2:0] st;
        logic [14:0] npc;
        int ds, ms;
        logic [5:0] comp;
        bit take;
        int unsigned lim;
        ins = w.instruction;
        o = '0;
        o.service_a = cpu_a;
        o.service_d = cpu_d;
        st = ST_OK;
        lim = (prog_len > 32768) ? 32768 : prog_len;
        if (cpu_pc >= lim) begin
            st = ST_HALT;
        end else if (!ins[15]) begin
            cpu_a = ins;
            cpu_pc = cpu_pc + 15'd1;
        end else if (!ins[14]) begin
            st = ST_IO;
        end else if (!ins[13]) begin
            st = ST_ILLEGAL;
        end else begin
            comp = ins[11:6];
            mv = ins[12] ? w.mem_read_data : cpu_a;
            ds = $signed(cpu_d);
            ms = $signed(mv);
            r = '0;
            case (comp)
                OP_AND: r = cpu_d & mv;
                OP_ADD: r = cpu_d + mv;
                OP_AMD: r = mv - cpu_d;
                OP_D: r = cpu_d;
                OP_NOTD: r = ~cpu_d;
                OP_DM1: r = cpu_d - 16'd1;
                OP_NEGD: r = -cpu_d;
                OP_DMA: r = cpu_d - mv;
                OP_OR: r = cpu_d | mv;
                OP_DP1: r = cpu_d + 16'd1;
                OP_A: r = mv;
                OP_NOTA: r = ~mv;
                OP_AM1: r = mv - 16'd1;
                OP_NEGA: r = -mv;
                OP_AP1: r = mv + 16'd1;
                OP_NEG1: r = 16'hFFFF;
                OP_ONE: r = 16'd1;
                OP_SHL: r = (mv >= 16) ? 16'd0 : cpu_d << mv;
                OP_SHR: r = (mv >= 16) ? {16{cpu_d[15]}} : 16'($signed(cpu_d) >>> mv);
                OP_MUL: r = cpu_d * mv;
                C_DIV: if (mv == 0) st = ST_DIVZERO; else r = 16'(ds / ms);
                C_MOD: if (mv == 0) st = ST_DIVZERO; else r = 16'(ds % ms);
                OP_LT: r = 16'(ds < ms);
                OP_LE: r = 16'(ds <= ms);
                OP_GT: r = 16'(ds > ms);
                OP_GE: r = 16'(ds >= ms);
                OP_EQ: r = 16'(cpu_d == mv);
                OP_NE: r = 16'(cpu_d != mv);
                OP_XOR: r = cpu_d ^ mv;
                OP_CALL, OP_RET: st = ST_CALLRET;
                OP_SVC: st = ST_SERVICE;
                default: r = '0;
            endcase
            if (st == ST_OK || st == ST_SERVICE) begin
                npc = cpu_pc + 15'd1;
                if (ins[5]) cpu_a = r;
                if (ins[4]) cpu_d = r;
                if (ins[3]) begin
                    o.mem_write = 1'b1;
                    o.mem_write_data = r;
                end
                case (ins[2:0])
                    J_GT: take = $signed(r) > 0;
                    J_EQ: take = r == 0;
                    J_GE: take = $signed(r) >= 0;
                    J_LT: take = $signed(r) < 0;
                    J_NE: take = r != 0;
                    J_LE: take = $signed(r) <= 0;
                    J_ALWAYS: take = 1'b1;
                    default: take = 1'b0;
                endcase
                if (take) npc = cpu_a[14:0];
                cpu_pc = npc;
            end
        end
        o.status = st;
        o.next_pc = cpu_pc;
        o.a_value = cpu_a;
        o.d_value = cpu_d;
        return o;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_instr(t_row row);
        int unsigned gap;
        t_out_word predicted;
        gap = in_throttle ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= row.w;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = execute_instr(row.w);
        pending_results.push_back(row.known ? row.exp : predicted);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_program_length(logic [15:0] len);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        prog_len = len;
    endtask

    function automatic t_row random_instr();
        t_row row;
        int unsigned pick;
        logic [5:0] comp;
        row.known = 1'b0;
        row.exp = '0;
        pick = $urandom_range(0, 99);
        row.w.mem_read_data = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 20))
                                                           : 16'($urandom);
        if (pick < 30) begin
            row.w.instruction = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 20))
                                                           : {1'b0, 15'($urandom)};
        end else if (pick < 93) begin
            comp = ($urandom_range(0, 5) == 0) ? (($urandom_range(0, 1) == 0) ? C_DIV : C_MOD)
                                               : 6'($urandom);
            row.w.instruction = cinstr(1'($urandom_range(0, 1)), comp, 3'($urandom),
                                       ($urandom_range(0, 2) == 0) ? 3'($urandom) : J_NONE);
        end else begin
            row.w.instruction = 16'($urandom);
        end
        return row;
    endfunction

    function automatic t_row dir_row(logic [15:0] ins, logic [15:0] mrd);
        t_row row;
        row.w.instruction = ins;
        row.w.mem_read_data = mrd;
        row.known = 1'b0;
        row.exp = '0;
        return row;
    endfunction

    always @(posedge i_clk) begin
        if (out_hold > 0) begin
            out_hold <= out_hold - 1;
            i_out_ready <= 1'b0;
        end else if (out_throttle && $urandom_range(0, 99) < 3) begin
            out_hold <= $urandom_range(10, 50);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !out_throttle || ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result word: %p", o_out);
            end else begin
                want = pending_results.pop_front();
                if (o_out !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, o_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [15:0] lengths[6];
        int unsigned counts[6];
        t_row halted;
        halted = dir_row(cinstr(1'b0, OP_ONE, DST_D, J_NONE), 16'h7FFF);
        halted.known = 1'b1;
        halted.exp = '{status: ST_HALT, default: '0};
        steps.push_back(dir_row(16'h7FFF, 16'h8000));
        steps.push_back(dir_row(cinstr(1'b0, OP_A, DST_D, J_NONE), 16'h0));
        steps.push_back(dir_row(16'h0001, 16'h0));
        steps.push_back(dir_row(cinstr(1'b0, OP_ADD, DST_D, J_NONE), 16'h0));
        steps.push_back(dir_row(cinstr(1'b0, OP_NEG1, DST_A, J_NONE), 16'h0));
        steps.push_back(dir_row(cinstr(1'b0, C_DIV, DST_D | DST_M, J_NONE), 16'h0));
        steps.push_back(dir_row(cinstr(1'b1, C_MOD, DST_M, J_NONE), 16'hFFFF));
        steps.push_back(dir_row(cinstr(1'b1, C_DIV, DST_D, J_NONE), 16'h0000));
        steps.push_back(dir_row(cinstr(1'b1, C_MOD, DST_D, J_NONE), 16'h0000));
        steps.push_back(dir_row(16'h8000, 16'h0));
        steps.push_back(dir_row(16'hC000, 16'h0));
        steps.push_back(dir_row(cinstr(1'b0, OP_CALL, DST_D, J_ALWAYS), 16'h0));
        steps.push_back(dir_row(cinstr(1'b0, OP_RET, DST_D, J_ALWAYS), 16'h0));
        steps.push_back(dir_row(cinstr(1'b0, OP_SVC, DST_D | DST_M, J_NONE), 16'h0));
        steps.push_back(dir_row(16'd20, 16'h0));
        steps.push_back(dir_row(cinstr(1'b0, OP_NEG1, DST_D, J_NONE), 16'h0));
        steps.push_back(dir_row(cinstr(1'b0, OP_SHR, DST_D, J_NONE), 16'h0));
        steps.push_back(dir_row(cinstr(1'b1, OP_SHR, DST_M, J_NONE), 16'hFFFB));
        steps.push_back(dir_row(cinstr(1'b1, OP_SHL, DST_D, J_NONE), 16'd16));
        steps.push_back(dir_row(cinstr(1'b1, OP_MUL, DST_M, J_LT), 16'h7FFF));
        steps.push_back(dir_row(cinstr(1'b1, OP_LT, DST_M, J_GT), 16'h8000));
        steps.push_back(dir_row(cinstr(1'b1, OP_XOR, DST_D, J_NONE), 16'hFFFF));
        steps.push_back(dir_row(cinstr(1'b0, OP_ZERO, DST_NONE, J_ALWAYS), 16'h0));
        steps.push_back(dir_row(cinstr(1'b0, OP_UNUSED, DST_D | DST_M, J_EQ), 16'h1));

        lengths = '{16'd32768, 16'd65535, 16'd40, 16'd32768, 16'd0, 16'd1};
        counts = '{350, 300, 150, 350, 50, 300};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_instr(halted);
        set_program_length(16'd32768);
        foreach (steps[k]) send_instr(steps[k]);

        for (int p = 0; p < 6; p++) begin
            set_program_length(lengths[p]);
            in_throttle = (p != 0);
            out_throttle = (p != 3);
            for (int k = 0; k < counts[p]; k++) begin
                if (p == 1 && k == 150) wait_drained();
                send_instr(random_instr());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
